FILE: sv/bbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsm_pkg
// Shared types and field widths for the buddy block split/merge engine.
// ----------------------------------------------------------------------------
package bbsm_pkg;

    localparam int MODE_W  = 3;
    localparam int INDEX_W = 10;
    localparam int ORDER_W = 4;
    localparam int CFG_W   = 4;

    // top order after reset
    localparam logic [CFG_W-1:0] TOP_ORDER_RESET = 4'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT    = 3'd0,
        MODE_SPLIT   = 3'd1,
        MODE_MERGE   = 3'd2,
        MODE_TAKE    = 3'd3,
        MODE_RELEASE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PAIR,
        ST_SPLIT2
    } state_t;

endpackage

FILE: sv/bbsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsm_cmd_if / bbsm_rsp_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface bbsm_cmd_if
    import bbsm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output mode, output block_index, input ready);
    modport sink   (input valid, input mode, input block_index, output ready);
endinterface

interface bbsm_rsp_if
    import bbsm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [INDEX_W-1:0] result_index;
    logic [ORDER_W-1:0] result_order;

    modport source (output valid, output ok, output result_index, output result_order,
                    input ready);
    modport sink   (input valid, input ok, input result_index, input result_order,
                    output ready);
endinterface

FILE: sv/buddy_block_split_merge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_split_merge_core
// Buddy allocator metadata engine: init, split, merge, take and release.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation word (mode, block_index); rsp returns exactly
//   one result word (ok, result_index, result_order) per operation.
//   cfg_wr_en / cfg_wr_data write top_order; write it only while idle.
//   Metadata (order and free mark per unit) lives in one memory with a
//   registered read and one write port.
// Sequence:
//   init, take and release: read, then write back; refusals: read only.
//   split: read and write of the lower half, then a second write for the upper buddy.
//   merge: read, then a second read for the buddy entry, then the write back on success.
//   one operation is in flight at a time; cmd.ready is high only when idle.
// Reset:
//   control state clears and top_order returns to 10; the metadata memory
//   is not cleared, so issue init before any other operation.
// Stall:
//   a result waits in the output register while rsp.ready is low; the next
//   operation may be accepted meanwhile but completes only after the slot
//   frees; only a split writes its lower half before then.
// ----------------------------------------------------------------------------
module buddy_block_split_merge_core
    import bbsm_pkg::*;
#(
    parameter int UNIT_COUNT_LOG = 10
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    bbsm_cmd_if.sink            cmd,
    bbsm_rsp_if.source          rsp
);

    localparam int N  = UNIT_COUNT_LOG;
    localparam int OW = $clog2(N + 1);
    localparam int EW = OW + 1;
    localparam logic [N-1:0] ONE_N = N'(1);

    // configuration
    logic [CFG_W-1:0] top_order_reg;
    logic [OW-1:0]    top_eff;

    // metadata memory: {order, free}
    logic [EW-1:0] mem [2**N];
    logic [EW-1:0] rd_data_reg;
    logic [N-1:0]  rd_addr;
    logic          mem_we;
    logic [N-1:0]  mem_waddr;
    logic [EW-1:0] mem_wdata;

    // control and per-operation registers
    state_t        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [N-1:0]  idx_reg, idx_next;
    logic [N-1:0]  buddy_reg, buddy_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic          free_reg, free_next;

    // output register
    logic               out_valid_reg;
    logic               out_ok_reg, out_ok_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [ORDER_W-1:0] out_order_reg, out_order_next;
    logic               load_out;
    logic               slot_free;

    // lookup decode
    logic [N-1:0]  cmd_idx;
    logic [OW-1:0] rd_ord;
    logic          rd_free;
    logic          in_pool;
    logic          aligned;
    logic [N-1:0]  low_mask;
    logic [N-1:0]  pair_bit;
    logic [N-1:0]  left_idx;
    logic          cmd_accept;

    assign top_eff = ({1'b0, top_order_reg} > 5'(N)) ? OW'(N) : OW'(top_order_reg);
    assign cmd_idx = N'(cmd.block_index);
    assign rd_ord  = rd_data_reg[EW-1:1];
    assign rd_free = rd_data_reg[0];
    assign in_pool = ((idx_reg >> top_eff) == '0);
    assign low_mask = ~({N{1'b1}} << rd_ord);
    assign aligned  = (rd_ord <= top_eff) && ((idx_reg & low_mask) == '0);
    assign pair_bit = ONE_N << ord_reg;
    assign left_idx = idx_reg & ~pair_bit;
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_order_reg <= TOP_ORDER_RESET;
        end
        else if (cfg_wr_en)
        begin
            top_order_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        buddy_reg <= buddy_next;
        ord_reg   <= ord_next;
        free_reg  <= free_next;
        if (load_out)
        begin
            out_ok_reg    <= out_ok_next;
            out_index_reg <= out_index_next;
            out_order_reg <= out_order_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        buddy_next     = buddy_reg;
        ord_next       = ord_reg;
        free_next      = free_reg;
        rd_addr        = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        load_out       = 1'b0;
        out_ok_next    = 1'b0;
        out_index_next = INDEX_W'(idx_reg);
        out_order_next = ORDER_W'(rd_ord);
        cmd.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                rd_addr   = cmd_idx;
                if (cmd.valid)
                begin
                    idx_next   = cmd_idx;
                    mode_next  = cmd.mode;
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                // default path is a refusal with the stored order
                case (mode_reg)
                    MODE_INIT:
                    begin
                        if (slot_free)
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = '0;
                            mem_wdata      = {top_eff, 1'b1};
                            load_out       = 1'b1;
                            out_ok_next    = 1'b1;
                            out_index_next = '0;
                            out_order_next = ORDER_W'(top_eff);
                            state_next     = ST_IDLE;
                        end
                    end
                    MODE_SPLIT:
                    begin
                        if (!in_pool || rd_ord == '0 || !aligned)
                        begin
                            if (slot_free)
                            begin
                                load_out   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = {OW'(rd_ord - 1'b1), 1'b1};
                            buddy_next = idx_reg ^ (ONE_N << (rd_ord - 1'b1));
                            ord_next   = OW'(rd_ord - 1'b1);
                            state_next = ST_SPLIT2;
                        end
                    end
                    MODE_MERGE:
                    begin
                        if (!in_pool || rd_ord >= top_eff || !aligned)
                        begin
                            if (slot_free)
                            begin
                                load_out   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            // fetch the buddy entry next
                            rd_addr    = idx_reg ^ (ONE_N << rd_ord);
                            ord_next   = rd_ord;
                            free_next  = rd_free;
                            state_next = ST_PAIR;
                        end
                    end
                    MODE_TAKE, MODE_RELEASE:
                    begin
                        if (slot_free)
                        begin
                            if (in_pool)
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = {rd_ord, (mode_reg == MODE_RELEASE)};
                                out_ok_next = 1'b1;
                            end
                            load_out   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            load_out   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_PAIR:
            begin
                rd_addr        = idx_reg ^ pair_bit;
                out_order_next = ORDER_W'(ord_reg);
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (rd_ord == ord_reg && free_reg && rd_free)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = left_idx;
                        mem_wdata      = {OW'(ord_reg + 1'b1), 1'b1};
                        out_ok_next    = 1'b1;
                        out_index_next = INDEX_W'(left_idx);
                        out_order_next = ORDER_W'(OW'(ord_reg + 1'b1));
                    end
                end
            end

            ST_SPLIT2:
            begin
                if (slot_free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = buddy_reg;
                    mem_wdata      = {ord_reg, 1'b1};
                    load_out       = 1'b1;
                    out_ok_next    = 1'b1;
                    out_index_next = INDEX_W'(buddy_reg);
                    out_order_next = ORDER_W'(ord_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.result_order = out_order_reg;

    // an accepted word always goes to the lookup step
    a_accept_to_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg == ST_LOOKUP)
    ) else $error("accepted word did not start a lookup");

    // metadata is never written while idle
    a_no_idle_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE)
    ) else $error("memory write while idle");

    // merge write back only together with its result
    a_merge_write_with_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_PAIR) |-> load_out
    ) else $error("merge wrote metadata without delivering a result");

    // a result is only produced by an operation in flight
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        load_out |-> (state_reg != ST_IDLE)
    ) else $error("result produced with no operation in flight");

endmodule
